// ===== rtl/core/rit_pkg.sv =====
package rit_pkg;

  localparam int LEVELS          = 3;
  localparam int MAX_LEVEL_BITS  = 8;
  localparam int NODE_POOL       = 256;
  localparam int VERTEX_CAPACITY = 65536;

  localparam int CFG_REGS  = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int LB_W      = 4;
  localparam int ACT_W     = 2;
  localparam int ST_W      = 2;
  localparam int ID_W      = 24;
  localparam int TS_W      = 32;
  localparam int VTX_W     = 16;
  localparam int VCNT_W    = 17;
  localparam int NODE_W    = 8;
  localparam int NFN_W     = 9;
  localparam int SLOT_W    = MAX_LEVEL_BITS;
  localparam int ADDR_W    = NODE_W + SLOT_W;
  localparam int ENTRY_W   = VTX_W + 1;
  localparam int LVL_W     = 2;
  localparam int SHAMT_W   = 5;
  localparam int STORE_DEPTH = NODE_POOL << MAX_LEVEL_BITS;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2 = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SHAMT_W-1:0] shamt;
    logic [LB_W-1:0]    nbits;
  } slot_req_t;

  function automatic logic [LB_W-1:0] clamp_bits(input logic [CFG_W-1:0] v);
    logic [LB_W-1:0] b;
    if (v == '0) begin
      b = LB_W'(1);
    end else if (v > CFG_W'(MAX_LEVEL_BITS)) begin
      b = LB_W'(MAX_LEVEL_BITS);
    end else begin
      b = v;
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/rit_ram.sv =====
module rit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/rit_slot_unit.sv =====
module rit_slot_unit (
  input  rit_pkg::slot_req_t           req,
  output logic [rit_pkg::SLOT_W-1:0]   slot
);
  import rit_pkg::*;

  logic [ID_W-1:0]   shifted;
  logic [SLOT_W-1:0] mask;

  always_comb begin
    shifted = req.id >> req.shamt;
    mask    = ~({SLOT_W{1'b1}} << req.nbits);
    slot    = shifted[SLOT_W-1:0] & mask;
  end

endmodule

// ===== rtl/core/rit_ctrl.sv =====
module rit_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rit_pkg::ACT_W-1:0]      in_action,
  input  logic [rit_pkg::ID_W-1:0]       in_vertex_id,
  input  logic [rit_pkg::TS_W-1:0]       in_timestamp,
  output logic                           out_valid,
  output logic [rit_pkg::ST_W-1:0]       out_status,
  output logic [rit_pkg::VTX_W-1:0]      out_vertex_index,
  output logic                           out_created,
  output logic [rit_pkg::TS_W-1:0]       out_deletion_time,
  input  logic                           cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rit_pkg::CFG_W-1:0]      cfg_wdata,
  output rit_pkg::slot_req_t             slot_req,
  input  logic [rit_pkg::SLOT_W-1:0]     slot,
  output logic                           node_we,
  output logic [rit_pkg::ADDR_W-1:0]     node_wr_addr,
  output logic [rit_pkg::ENTRY_W-1:0]    node_wr_data,
  output logic [rit_pkg::ADDR_W-1:0]     node_rd_addr,
  input  logic [rit_pkg::ENTRY_W-1:0]    node_rd_data,
  output logic                           dt_we,
  output logic [rit_pkg::VTX_W-1:0]      dt_wr_addr,
  output logic [rit_pkg::TS_W-1:0]       dt_wr_data,
  output logic [rit_pkg::VTX_W-1:0]      dt_rd_addr,
  input  logic [rit_pkg::TS_W-1:0]       dt_rd_data
);
  import rit_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_INSERT,
    S_DTREAD
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [CFG_W-1:0]   level_r [CFG_REGS];
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [NFN_W-1:0]   nfn_r, nfn_nxt;
  logic [VCNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_status_r, out_status_nxt;
  logic [VTX_W-1:0]   out_index_r, out_index_nxt;
  logic               out_created_r, out_created_nxt;
  logic [TS_W-1:0]    out_dtime_r, out_dtime_nxt;

  logic [LB_W-1:0]    lvl_bits [LEVELS];
  logic [SHAMT_W-1:0] shamt;
  logic [NFN_W:0]     nfn_need;
  logic               full;

  always_comb begin
    for (int j = 0; j < LEVELS; j++) begin
      lvl_bits[j] = clamp_bits(level_r[(j < CFG_REGS - 1) ? j : CFG_REGS - 1]);
    end
    shamt = '0;
    for (int j = 0; j < LEVELS; j++) begin
      if (LVL_W'(j) > lvl_r) begin
        shamt = shamt + SHAMT_W'(lvl_bits[j]);
      end
    end
    slot_req.id    = id_r;
    slot_req.shamt = shamt;
    slot_req.nbits = lvl_bits[lvl_r];
  end

  always_comb begin
    nfn_need = {1'b0, nfn_r} + (NFN_W+1)'(LEVELS - 1) - (NFN_W+1)'(lvl_r);
    full     = (nfn_need > (NFN_W+1)'(NODE_POOL)) ||
               (vcnt_r >= VCNT_W'(VERTEX_CAPACITY));
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    act_nxt         = act_r;
    id_nxt          = id_r;
    ts_nxt          = ts_r;
    cur_nxt         = cur_r;
    lvl_nxt         = lvl_r;
    nfn_nxt         = nfn_r;
    vcnt_nxt        = vcnt_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_index_nxt   = out_index_r;
    out_created_nxt = out_created_r;
    out_dtime_nxt   = out_dtime_r;
    node_we         = 1'b0;
    node_wr_addr    = {cur_r, slot};
    node_wr_data    = '0;
    node_rd_addr    = {cur_r, slot};
    dt_we           = 1'b0;
    dt_wr_addr      = vcnt_r[VTX_W-1:0];
    dt_wr_data      = '0;
    dt_rd_addr      = node_rd_data[VTX_W-1:0];

    unique case (state_r)
      S_CLEAR: begin
        node_we      = 1'b1;
        node_wr_addr = clr_r;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          id_nxt    = in_vertex_id;
          ts_nxt    = in_timestamp;
          cur_nxt   = '0;
          lvl_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!node_rd_data[ENTRY_W-1]) begin
          if (act_r == ACT_INSERT) begin
            if (full) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = ST_FULL;
              out_index_nxt   = '0;
              out_created_nxt = 1'b0;
              out_dtime_nxt   = '0;
              state_nxt       = S_IDLE;
            end else begin
              state_nxt = S_INSERT;
            end
          end else begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ST_NOTFOUND;
            out_index_nxt   = '0;
            out_created_nxt = 1'b0;
            out_dtime_nxt   = '0;
            state_nxt       = S_IDLE;
          end
        end else if (lvl_r != LVL_W'(LEVELS - 1)) begin
          cur_nxt   = node_rd_data[NODE_W-1:0];
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_READ;
        end else begin
          out_index_nxt   = node_rd_data[VTX_W-1:0];
          out_status_nxt  = ST_FOUND;
          out_created_nxt = 1'b0;
          if (act_r == ACT_DELETE) begin
            dt_we         = 1'b1;
            dt_wr_addr    = node_rd_data[VTX_W-1:0];
            dt_wr_data    = ts_r;
            out_dtime_nxt = ts_r;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_DTREAD;
          end
        end
      end
      S_INSERT: begin
        node_we = 1'b1;
        if (lvl_r != LVL_W'(LEVELS - 1)) begin
          node_wr_data = {1'b1, {(VTX_W-NODE_W){1'b0}}, nfn_r[NODE_W-1:0]};
          cur_nxt      = nfn_r[NODE_W-1:0];
          nfn_nxt      = nfn_r + 1'b1;
          lvl_nxt      = lvl_r + 1'b1;
        end else begin
          node_wr_data    = {1'b1, vcnt_r[VTX_W-1:0]};
          dt_we           = 1'b1;
          vcnt_nxt        = vcnt_r + 1'b1;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_FOUND;
          out_index_nxt   = vcnt_r[VTX_W-1:0];
          out_created_nxt = 1'b1;
          out_dtime_nxt   = '0;
          state_nxt       = S_IDLE;
        end
      end
      S_DTREAD: begin
        out_valid_nxt = 1'b1;
        out_dtime_nxt = dt_rd_data;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nfn_r       <= NFN_W'(1);
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
      level_r[0]  <= CFG_W'(MAX_LEVEL_BITS);
      level_r[1]  <= CFG_W'(MAX_LEVEL_BITS);
      level_r[2]  <= CFG_W'(MAX_LEVEL_BITS);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nfn_r       <= nfn_nxt;
      vcnt_r      <= vcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEVEL0: level_r[0] <= cfg_wdata;
          CFG_LEVEL1: level_r[1] <= cfg_wdata;
          CFG_LEVEL2: level_r[2] <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    act_r         <= act_nxt;
    id_r          <= id_nxt;
    ts_r          <= ts_nxt;
    cur_r         <= cur_nxt;
    lvl_r         <= lvl_nxt;
    out_status_r  <= out_status_nxt;
    out_index_r   <= out_index_nxt;
    out_created_r <= out_created_nxt;
    out_dtime_r   <= out_dtime_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_vertex_index  = out_index_r;
  assign out_created       = out_created_r;
  assign out_deletion_time = out_dtime_r;

endmodule

// ===== rtl/core/radix_id_table.sv =====
// Maps a sparse 24-bit vertex id to a dense vertex index through a three-level
// radix tree held in a node memory, with a second memory of deletion times.
// A command word is taken at a clock edge where start is high and busy is low.
// Each command gives exactly one result word, shown on the out_ ports for one
// cycle with out_valid high; the receiver cannot stall and must take it then.
// Each tree level walked passes through a read state and a check state, as
// the node memory is read once per level with a registered read; an insert
// then passes through one insert state for each node entry written, and a
// hit on any action but a delete adds a deletion-time read state.
// Busy is high from acceptance until the result, so one command is in flight
// at once; the next may start in the cycle that out_valid is shown.
// After reset all 65536 node entries are cleared one entry a cycle, with
// busy high; level-width registers may be written on the cfg_ port only while
// no command is in flight, and take effect at once.
module radix_id_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rit_pkg::ACT_W-1:0]      in_action,
  input  logic [rit_pkg::ID_W-1:0]       in_vertex_id,
  input  logic [rit_pkg::TS_W-1:0]       in_timestamp,
  output logic                           out_valid,
  output logic [rit_pkg::ST_W-1:0]       out_status,
  output logic [rit_pkg::VTX_W-1:0]      out_vertex_index,
  output logic                           out_created,
  output logic [rit_pkg::TS_W-1:0]       out_deletion_time,
  input  logic                           cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rit_pkg::CFG_W-1:0]      cfg_wdata
);
  import rit_pkg::*;

  slot_req_t          slot_req;
  logic [SLOT_W-1:0]  slot;
  logic               node_we;
  logic [ADDR_W-1:0]  node_wr_addr;
  logic [ENTRY_W-1:0] node_wr_data;
  logic [ADDR_W-1:0]  node_rd_addr;
  logic [ENTRY_W-1:0] node_rd_data;
  logic               dt_we;
  logic [VTX_W-1:0]   dt_wr_addr;
  logic [TS_W-1:0]    dt_wr_data;
  logic [VTX_W-1:0]   dt_rd_addr;
  logic [TS_W-1:0]    dt_rd_data;

  rit_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_vertex_id      (in_vertex_id),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_vertex_index  (out_vertex_index),
    .out_created       (out_created),
    .out_deletion_time (out_deletion_time),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .slot_req          (slot_req),
    .slot              (slot),
    .node_we           (node_we),
    .node_wr_addr      (node_wr_addr),
    .node_wr_data      (node_wr_data),
    .node_rd_addr      (node_rd_addr),
    .node_rd_data      (node_rd_data),
    .dt_we             (dt_we),
    .dt_wr_addr        (dt_wr_addr),
    .dt_wr_data        (dt_wr_data),
    .dt_rd_addr        (dt_rd_addr),
    .dt_rd_data        (dt_rd_data)
  );

  rit_slot_unit u_slot (
    .req  (slot_req),
    .slot (slot)
  );

  rit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data)
  );

  rit_ram #(
    .WIDTH (TS_W),
    .DEPTH (VERTEX_CAPACITY)
  ) u_dt_ram (
    .clk     (clk),
    .we      (dt_we),
    .wr_addr (dt_wr_addr),
    .wr_data (dt_wr_data),
    .rd_addr (dt_rd_addr),
    .rd_data (dt_rd_data)
  );

endmodule

// ===== sim/radix_id_table_test.sv =====
module radix_id_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rit_pkg::*;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VTX_W-1:0] index;
    logic             created;
    logic [TS_W-1:0]  dtime;
  } lookup_word_t;

  class vertex_map_scoreboard;
    bit [ENTRY_W-1:0] node_mem [STORE_DEPTH];
    bit [TS_W-1:0]    dtime_mem [VERTEX_CAPACITY];
    int unsigned      next_node;
    int unsigned      vtx_count;
    int unsigned      level_cfg [CFG_REGS];
    lookup_word_t     due_words [$];
    int               mismatches;

    function new();
      next_node = 1;
      vtx_count = 0;
      mismatches = 0;
      foreach (level_cfg[i]) level_cfg[i] = 8;
    endfunction

    function void set_level(int unsigned idx, int unsigned val);
      level_cfg[idx] = val;
    endfunction

    function int unsigned level_width(int lv);
      int unsigned b;
      b = level_cfg[lv < 2 ? lv : 2];
      if (b < 1) b = 1;
      if (b > MAX_LEVEL_BITS) b = MAX_LEVEL_BITS;
      return b;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void note_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                               logic [TS_W-1:0] ts);
      int unsigned  eff [LEVELS];
      int unsigned  slot [LEVELS];
      int unsigned  total, used, cur, addr, need, nn, vi, idv;
      int           miss_lvl;
      bit           hit;
      lookup_word_t w;
      total = 0;
      for (int lv = 0; lv < LEVELS; lv++) begin
        eff[lv] = level_width(lv);
        total += eff[lv];
      end
      idv = 32'(id);
      used = 0;
      for (int lv = 0; lv < LEVELS; lv++) begin
        used += eff[lv];
        slot[lv] = (idv >> (total - used)) & ((1 << eff[lv]) - 1);
      end
      cur = 0;
      addr = 0;
      miss_lvl = -1;
      hit = 1'b0;
      for (int lv = 0; lv < LEVELS && miss_lvl < 0 && !hit; lv++) begin
        addr = ((cur % NODE_POOL) << MAX_LEVEL_BITS) | slot[lv];
        if (!node_mem[addr][VTX_W]) begin
          miss_lvl = lv;
        end else if (lv == LEVELS - 1) begin
          hit = 1'b1;
        end else begin
          cur = 32'(node_mem[addr][VTX_W-1:0]);
        end
      end
      w.status = ST_NOTFOUND;
      w.index = '0;
      w.created = 1'b0;
      w.dtime = '0;
      if (hit) begin
        vi = 32'(node_mem[addr][VTX_W-1:0]);
        if (act == ACT_DELETE) dtime_mem[vi] = ts;
        w.status = ST_FOUND;
        w.index = VTX_W'(vi);
        w.dtime = dtime_mem[vi];
      end else if (act == ACT_INSERT) begin
        need = LEVELS - 1 - miss_lvl;
        if (next_node + need > NODE_POOL || vtx_count >= VERTEX_CAPACITY) begin
          w.status = ST_FULL;
        end else begin
          for (int lv = miss_lvl; lv < LEVELS - 1; lv++) begin
            nn = next_node++;
            node_mem[(cur << MAX_LEVEL_BITS) | slot[lv]] = {1'b1, VTX_W'(nn)};
            cur = nn;
          end
          vi = vtx_count++;
          node_mem[(cur << MAX_LEVEL_BITS) | slot[LEVELS-1]] = {1'b1, VTX_W'(vi)};
          dtime_mem[VTX_W'(vi)] = '0;
          w.status = ST_FOUND;
          w.index = VTX_W'(vi);
          w.created = 1'b1;
        end
      end
      due_words.push_back(w);
    endfunction

    function void check_result(lookup_word_t got);
      lookup_word_t w;
      if (due_words.size() == 0) begin
        report($sformatf("result word with none expected: status %0d index %0d",
                         got.status, got.index));
      end else begin
        w = due_words.pop_front();
        if (got.status !== w.status || got.index !== w.index ||
            got.created !== w.created || got.dtime !== w.dtime) begin
          report($sformatf({"mismatch: expected status %0d index %0d created %0d ",
                            "dtime %h, got status %0d index %0d created %0d dtime %h"},
                           w.status, w.index, w.created, w.dtime,
                           got.status, got.index, got.created, got.dtime));
        end
      end
    endfunction

    function void check_drained();
      if (due_words.size() != 0)
        report($sformatf("%0d result words never arrived", due_words.size()));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ACT_W-1:0]     in_action = '0;
  logic [ID_W-1:0]      in_vertex_id = '0;
  logic [TS_W-1:0]      in_timestamp = '0;
  logic                 out_valid;
  logic [ST_W-1:0]      out_status;
  logic [VTX_W-1:0]     out_vertex_index;
  logic                 out_created;
  logic [TS_W-1:0]      out_deletion_time;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  vertex_map_scoreboard map_sb;
  logic [ID_W-1:0]      known_ids [$];
  bit                   gaps_on;

  radix_id_table u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_vertex_id      (in_vertex_id),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_vertex_index  (out_vertex_index),
    .out_created       (out_created),
    .out_deletion_time (out_deletion_time),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    lookup_word_t got;
    if (rst_n && out_valid) begin
      got.status = out_status;
      got.index = out_vertex_index;
      got.created = out_created;
      got.dtime = out_deletion_time;
      map_sb.check_result(got);
    end
  end

  task automatic send(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                      input logic [TS_W-1:0] ts);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_vertex_id <= id;
    in_timestamp <= ts;
    do @(posedge clk); while (busy);
    map_sb.note_command(act, id, ts);
    if (act == ACT_INSERT) known_ids.push_back(id);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (map_sb.pending() != 0 || busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    map_sb.set_level(32'(idx), 32'(val));
    @(posedge clk);
  endtask

  task automatic write_levels(input int unsigned a, input int unsigned b,
                              input int unsigned c);
    write_reg(CFG_LEVEL0, CFG_W'(a));
    write_reg(CFG_LEVEL1, CFG_W'(b));
    write_reg(CFG_LEVEL2, CFG_W'(c));
    cfg_we <= 1'b0;
  endtask

  task automatic random_words(input int count, input int insert_pct, input int reuse_pct);
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  id;
    int               r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) act = ACT_INSERT;
      else if (r % 10 < 5) act = ACT_LOOKUP;
      else if (r % 10 < 9) act = ACT_DELETE;
      else act = ACT_SPARE;
      if (known_ids.size() > 0 && $urandom_range(0, 99) < reuse_pct) begin
        id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        if ($urandom_range(0, 3) == 0) id ^= ID_W'(1) << $urandom_range(0, ID_W - 1);
      end else begin
        id = ID_W'($urandom);
      end
      send(act, id, $urandom);
    end
  endtask

  initial begin
    map_sb = new();
    gaps_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send(ACT_LOOKUP, 24'h000000, 32'h0);
    send(ACT_DELETE, 24'h000000, 32'h5);
    send(ACT_SPARE,  24'h000000, 32'h0);
    send(ACT_INSERT, 24'h000000, 32'h0);
    send(ACT_INSERT, 24'h000000, 32'h0);
    send(ACT_SPARE,  24'h000000, 32'h0);
    send(ACT_DELETE, 24'h000000, 32'hFFFF_FFFF);
    send(ACT_LOOKUP, 24'h000000, 32'h0);
    send(ACT_INSERT, 24'hFFFFFF, 32'hFFFF_FFFF);
    send(ACT_LOOKUP, 24'hFFFFFE, 32'h0);
    send(ACT_LOOKUP, 24'hFFFEFF, 32'h0);
    send(ACT_INSERT, 24'hFF0000, 32'h0);
    send(ACT_DELETE, 24'hFFFFFF, 32'h0);
    send(ACT_DELETE, 24'hFFFFFF, 32'h8000_0001);
    send(ACT_INSERT, 24'h000001, 32'h0);
    wait_idle();

    // A zero width counts as one bit and anything above eight as eight;
    // the tree built so far is read again under the new split.
    write_levels(0, 15, 9);
    send(ACT_LOOKUP, 24'h000000, 32'h0);
    send(ACT_LOOKUP, 24'hFFFFFF, 32'h0);
    send(ACT_INSERT, 24'hFE0000, 32'h0);
    send(ACT_INSERT, 24'h01FFFF, 32'h0);
    send(ACT_DELETE, 24'h01FFFF, $urandom);
    send(ACT_LOOKUP, 24'hFEFFFF, 32'h0);
    wait_idle();

    write_levels(1, 1, 1);
    send(ACT_INSERT, 24'hFFFFF8, 32'h0);
    send(ACT_INSERT, 24'h000007, 32'h0);
    send(ACT_LOOKUP, 24'hABCDE7, 32'h0);
    random_words(40, 40, 60);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      gaps_on = p[0];
      write_levels($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4));
      random_words(65, 40, 50);
      wait_idle();
    end

    // Wide split with mostly fresh ids, so the node pool runs dry.
    gaps_on = 1'b0;
    write_levels(8, 8, 8);
    random_words(240, 55, 30);
    wait_idle();

    repeat (12) @(posedge clk);
    map_sb.check_drained();
    if (map_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
